// ===== src/bles_pkg.sv =====
// bles_pkg: shared types, layout tables and byte reversal for the block layout endian swapper
// no dependencies
package bles_pkg;

    localparam int WordWidth = 32;
    localparam int TypeWidth = 4;
    localparam int RunWidth  = 3;
    localparam int CountWidth = 8;
    localparam int NumTypes  = 12;
    localparam int MaxRuns   = 6;
    localparam int TypeSlots = 1 << TypeWidth;
    localparam int RunSlots  = 1 << RunWidth;

    typedef logic [WordWidth-1:0]  word_t;
    typedef logic [TypeWidth-1:0]  type_t;
    typedef logic [RunWidth-1:0]   run_idx_t;
    typedef logic [CountWidth-1:0] count_t;

    // accepted input item
    typedef struct packed {
        word_t word;
        logic  first;
        type_t block_type;
    } in_item_t;

    // per-item flags from the layout walker
    typedef struct packed {
        logic swapped;
        logic layout_end;
        logic bad_type;
    } walk_t;

    // run lengths in words, unused slots zero
    localparam count_t RUN_COUNT [TypeSlots][RunSlots] = '{
        '{8'd1,   8'd2,   8'd253, 8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd108, 8'd10,  8'd10,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd6,   8'd122, 8'd0,   8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd82,  8'd23,  8'd3,   8'd9,  8'd11, 8'd0,  8'd0, 8'd0},
        '{8'd6,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd128, 8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd6,   8'd16,  8'd86,  8'd8,  8'd12, 8'd0,  8'd0, 8'd0},
        '{8'd1,   8'd39,  8'd14,  8'd10, 8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd1,   8'd127, 8'd0,   8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd1,   8'd8,   8'd8,   8'd31, 8'd1,  8'd15, 8'd0, 8'd0},
        '{8'd1,   8'd7,   8'd1,   8'd55, 8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd1,   8'd4,   8'd123, 8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0,  8'd0, 8'd0}
    };

    // bit n set when run n holds integers
    localparam logic [RunSlots-1:0] RUN_INT [TypeSlots] = '{
        8'b0000_0010, 8'b0000_0101, 8'b0000_0001, 8'b0001_0101,
        8'b0000_0001, 8'b0000_0001, 8'b0001_0101, 8'b0000_1010,
        8'b0000_0010, 8'b0010_1010, 8'b0000_1010, 8'b0000_0010,
        8'b0000_0000, 8'b0000_0000, 8'b0000_0000, 8'b0000_0000
    };

    localparam run_idx_t RUN_TOTAL [TypeSlots] = '{
        3'd3, 3'd3, 3'd2, 3'd5, 3'd1, 3'd1, 3'd5, 3'd4,
        3'd2, 3'd6, 3'd4, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0
    };

    function automatic word_t byte_reverse(input word_t w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ===== src/bles_in_reg.sv =====
// bles_in_reg: input register stage of the block layout endian swapper
// depends on bles_pkg
module bles_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bles_pkg::in_item_t in_item,
    output logic              item_valid,
    input  logic              item_take,
    output bles_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    bles_pkg::in_item_t item_reg;
    logic               load;

    assign in_ready   = !valid_reg || item_take;
    assign load       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/bles_walker.sv =====
// bles_walker: layout state and per-word swap and end flags
// depends on bles_pkg
module bles_walker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  bles_pkg::in_item_t item,
    output bles_pkg::walk_t    walk
);

    bles_pkg::type_t    layout_reg;
    bles_pkg::type_t    layout_next;
    bles_pkg::run_idx_t run_reg;
    bles_pkg::run_idx_t run_next;
    bles_pkg::count_t   left_reg;
    bles_pkg::count_t   left_next;
    logic               finished_reg;
    logic               finished_next;
    logic               invalid_reg;
    logic               invalid_next;

    bles_pkg::type_t    cur_layout;
    bles_pkg::run_idx_t cur_run;
    bles_pkg::count_t   cur_left;
    logic               cur_finished;
    bles_pkg::count_t   dec_left;
    bles_pkg::run_idx_t run_inc;
    logic               swap;
    logic               at_end;

    always_comb
    begin
        cur_layout   = layout_reg;
        cur_run      = run_reg;
        cur_left     = left_reg;
        cur_finished = finished_reg;
        invalid_next = invalid_reg;
        if (item.first)
        begin
            if (item.block_type >= bles_pkg::TypeWidth'(bles_pkg::NumTypes))
            begin
                invalid_next = 1'b1;
                cur_finished = 1'b1;
            end
            else
            begin
                invalid_next = 1'b0;
                cur_layout   = item.block_type;
                cur_run      = '0;
                cur_left     = bles_pkg::RUN_COUNT[item.block_type][0];
                cur_finished = 1'b0;
            end
        end

        layout_next   = cur_layout;
        run_next      = cur_run;
        left_next     = cur_left;
        finished_next = cur_finished;
        swap          = 1'b0;
        at_end        = 1'b0;
        dec_left      = (cur_left != '0) ? cur_left - 1'b1 : cur_left;
        run_inc       = cur_run + 1'b1;

        if (!cur_finished && cur_run < bles_pkg::RunWidth'(bles_pkg::MaxRuns))
        begin
            swap      = bles_pkg::RUN_INT[cur_layout][cur_run];
            left_next = dec_left;
            if (dec_left == '0)
            begin
                run_next = run_inc;
                if (run_inc >= bles_pkg::RUN_TOTAL[cur_layout]
                    || run_inc >= bles_pkg::RunWidth'(bles_pkg::MaxRuns))
                begin
                    finished_next = 1'b1;
                    at_end        = 1'b1;
                end
                else
                begin
                    left_next = bles_pkg::RUN_COUNT[cur_layout][run_inc];
                end
            end
        end
    end

    assign walk.swapped    = swap;
    assign walk.layout_end = at_end;
    assign walk.bad_type   = invalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg   <= '0;
            run_reg      <= '0;
            left_reg     <= '0;
            finished_reg <= 1'b1;
            invalid_reg  <= 1'b0;
        end
        else if (step)
        begin
            layout_reg   <= layout_next;
            run_reg      <= run_next;
            left_reg     <= left_next;
            finished_reg <= finished_next;
            invalid_reg  <= invalid_next;
        end
    end

endmodule

// ===== src/bles_out_reg.sv =====
// bles_out_reg: result register with byte reversal on load
// depends on bles_pkg
module bles_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  bles_pkg::word_t word,
    input  bles_pkg::walk_t walk,
    output logic            ready,
    output logic            out_valid,
    input  logic            out_ready,
    output bles_pkg::word_t out_word,
    output bles_pkg::walk_t out_walk
);

    logic            valid_reg;
    logic            valid_next;
    bles_pkg::word_t word_reg;
    bles_pkg::walk_t walk_reg;

    assign ready     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_walk  = walk_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= walk.swapped ? bles_pkg::byte_reverse(word) : word;
            walk_reg <= walk;
        end
    end

endmodule

// ===== src/block_layout_endian_swapper_top.sv =====
// block_layout_endian_swapper_top: top level of the block layout endian swapper
// depends on bles_pkg, bles_in_reg, bles_walker, bles_out_reg
//
// usage:
//   s_axis carries disk block words; tuser marks the first word of a block and its
//   layout type. m_axis returns each word, byte-reversed inside integer runs of the
//   layout, with tlast on the last word the layout covers.
// path: an accepted item waits in the input register until the result register can take
//   it, and is loaded there with its walk flags, byte-reversed inside integer runs.
// throughput: one item per cycle while m_axis_tready stays high; the layout walk is a
//   table lookup and an 8-bit count step done between the two registers.
// reset: both registers empty, no layout active, so words pass through unchanged
//   until a first word arrives.
// stall: when m_axis_tready is low the result register holds its item, the input
//   register holds one more, and s_axis_tready drops once both are full; no item is
//   lost or repeated.
module block_layout_endian_swapper_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // word_in
    input  logic [4:0]  s_axis_tuser,  // first, block_type[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // word_out
    output logic        m_axis_tlast,  // layout_end
    output logic [1:0]  m_axis_tuser   // swapped, bad_type
);

    bles_pkg::in_item_t in_item;
    bles_pkg::in_item_t item;
    logic               item_valid;
    logic               out_ready_int;
    logic               advance;
    bles_pkg::walk_t    walk;
    bles_pkg::walk_t    out_walk;

    assign in_item.word       = s_axis_tdata;
    assign in_item.first      = s_axis_tuser[0];
    assign in_item.block_type = s_axis_tuser[4:1];

    assign advance = item_valid && out_ready_int;

    bles_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (out_ready_int),
        .item       (item)
    );

    bles_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item),
        .walk  (walk)
    );

    bles_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .word      (item.word),
        .walk      (walk),
        .ready     (out_ready_int),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_walk  (out_walk)
    );

    assign m_axis_tlast = out_walk.layout_end;
    assign m_axis_tuser = {out_walk.bad_type, out_walk.swapped};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for block_layout_endian_swapper_top, directed rows then
// random disk blocks with random stalls on both streams; depends on bles_pkg and the rtl
module tb;

    localparam int unsigned RAND_ITEMS = 1525;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        bles_pkg::word_t word;
        logic            swapped;
        logic            layout_end;
        logic            bad_type;
    } res_t;

    typedef struct packed {
        bles_pkg::word_t word;
        logic            first;
        bles_pkg::type_t btype;
        logic            has_exp;
        res_t            exp;
    } row_t;

    // run lengths, integer flags and run counts per layout type
    localparam int LEN_TBL [12][6] = '{
        '{1, 2, 253, 0, 0, 0},
        '{108, 10, 10, 0, 0, 0},
        '{6, 122, 0, 0, 0, 0},
        '{82, 23, 3, 9, 11, 0},
        '{6, 0, 0, 0, 0, 0},
        '{128, 0, 0, 0, 0, 0},
        '{6, 16, 86, 8, 12, 0},
        '{1, 39, 14, 10, 0, 0},
        '{1, 127, 0, 0, 0, 0},
        '{1, 8, 8, 31, 1, 15},
        '{1, 7, 1, 55, 0, 0},
        '{1, 4, 123, 0, 0, 0}
    };
    localparam bit INT_TBL [12][6] = '{
        '{0, 1, 0, 0, 0, 0},
        '{1, 0, 1, 0, 0, 0},
        '{1, 0, 0, 0, 0, 0},
        '{1, 0, 1, 0, 1, 0},
        '{1, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 0, 0},
        '{1, 0, 1, 0, 1, 0},
        '{0, 1, 0, 1, 0, 0},
        '{0, 1, 0, 0, 0, 0},
        '{0, 1, 0, 1, 0, 1},
        '{0, 1, 0, 1, 0, 0},
        '{0, 1, 0, 0, 0, 0}
    };
    localparam int RUNS_TBL [12] = '{3, 3, 2, 5, 1, 1, 5, 4, 2, 6, 4, 3};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [4:0]  s_axis_tuser;   // first, block_type[3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // word_out
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;   // swapped, bad_type

    // predictor state
    bles_pkg::type_t    lay_type;
    bles_pkg::run_idx_t lay_run;
    bles_pkg::count_t   lay_left;
    logic               lay_done;
    logic               lay_bad;

    res_t        expected_words [$];
    row_t        directed_rows [$];
    int unsigned errors;
    bit          hold_req;

    block_layout_endian_swapper_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic res_t walk_layout(bles_pkg::in_item_t it);
        res_t r;
        r = '0;
        if (it.first)
        begin
            if (it.block_type >= bles_pkg::NumTypes)
            begin
                lay_bad = 1'b1;
                lay_done = 1'b1;
            end
            else
            begin
                lay_bad = 1'b0;
                lay_type = it.block_type;
                lay_run = '0;
                lay_left = bles_pkg::count_t'(LEN_TBL[it.block_type][0]);
                lay_done = 1'b0;
            end
        end
        if (!lay_done)
        begin
            r.swapped = INT_TBL[lay_type][lay_run];
            if (lay_left > 0)
                lay_left = lay_left - 1'b1;
            if (lay_left == 0)
            begin
                lay_run = lay_run + 1'b1;
                if (lay_run >= RUNS_TBL[lay_type])
                begin
                    lay_done = 1'b1;
                    r.layout_end = 1'b1;
                end
                else
                    lay_left = bles_pkg::count_t'(LEN_TBL[lay_type][lay_run]);
            end
        end
        r.word = r.swapped ? bles_pkg::byte_reverse(it.word) : it.word;
        r.bad_type = lay_bad;
        return r;
    endfunction

    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_row(bles_pkg::word_t w, logic f, bles_pkg::type_t t,
                                    logic has_exp, bles_pkg::word_t ew,
                                    logic sw, logic le, logic bad);
        row_t row;
        row.word = w;
        row.first = f;
        row.btype = t;
        row.has_exp = has_exp;
        row.exp = '{word: ew, swapped: sw, layout_end: le, bad_type: bad};
        directed_rows.push_back(row);
    endfunction

    task automatic send_word(bles_pkg::word_t w, logic f, bles_pkg::type_t t, logic has_exp,
                             res_t exp_r, int unsigned gap);
        bles_pkg::in_item_t it;
        res_t               pred;
        s_axis_tdata <= w;
        s_axis_tuser <= {t, f};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        it.word = w;
        it.first = f;
        it.block_type = t;
        pred = walk_layout(it);
        expected_words.push_back(has_exp ? exp_r : pred);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        res_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item %h", $time, m_axis_tdata);
            end
            else
            begin
                e = expected_words.pop_front();
                if (m_axis_tdata !== e.word)
                begin
                    errors++;
                    $display("%0t: word_out expected %h actual %h",
                             $time, e.word, m_axis_tdata);
                end
                if (m_axis_tuser[0] !== e.swapped)
                begin
                    errors++;
                    $display("%0t: swapped expected %b actual %b",
                             $time, e.swapped, m_axis_tuser[0]);
                end
                if (m_axis_tlast !== e.layout_end)
                begin
                    errors++;
                    $display("%0t: layout_end expected %b actual %b",
                             $time, e.layout_end, m_axis_tlast);
                end
                if (m_axis_tuser[1] !== e.bad_type)
                begin
                    errors++;
                    $display("%0t: bad_type expected %b actual %b",
                             $time, e.bad_type, m_axis_tuser[1]);
                end
            end
        end
    end

    // receiver
    initial
    begin
        int unsigned n;
        int unsigned r;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(1, 24);
                end
                else if (r < 90)
                begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(1, 3);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(8, 40);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    // timeout
    initial
    begin
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    // sender and run control
    initial
    begin
        int unsigned     sent;
        int unsigned     blk;
        int unsigned     len;
        int unsigned     mode;
        bles_pkg::type_t typ;
        bit              burst;
        row_t            row;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        errors = 0;
        hold_req = 1'b0;
        lay_type = '0;
        lay_run = '0;
        lay_left = '0;
        lay_done = 1'b1;
        lay_bad = 1'b0;

        // words before any block
        add_row(32'h0000_0000, 1'b0, 4'd0,  1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        add_row(32'hFFFF_FFFF, 1'b0, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        // invalid types
        add_row(32'h1234_5678, 1'b1, 4'd12, 1'b1, 32'h1234_5678, 1'b0, 1'b0, 1'b1);
        add_row(32'hA5A5_A5A5, 1'b0, 4'd0,  1'b1, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b1);
        add_row(32'h0F0F_0F0F, 1'b1, 4'd15, 1'b1, 32'h0F0F_0F0F, 1'b0, 1'b0, 1'b1);
        // short layout walked to its end, then a word past it
        add_row(32'h0123_4567, 1'b1, 4'd4,  1'b1, 32'h6745_2301, 1'b1, 1'b0, 1'b0);
        add_row(32'hFFFF_FFFF, 1'b0, 4'd7,  1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_row(32'h0000_0000, 1'b0, 4'd8,  1'b1, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        add_row(32'hCAFE_F00D, 1'b0, 4'd3,  1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row(32'h8000_0001, 1'b0, 4'd12, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row(32'h89AB_CDEF, 1'b0, 4'd0,  1'b1, 32'hEFCD_AB89, 1'b1, 1'b1, 1'b0);
        add_row(32'hDEAD_BEEF, 1'b0, 4'd4,  1'b1, 32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0);
        // every type in turn; all but type 0 restart mid-layout
        for (int t = 0; t < bles_pkg::NumTypes; t++)
            add_row(bles_pkg::word_t'($urandom), 1'b1, bles_pkg::type_t'(t), 1'b0, '0,
                    1'b0, 1'b0, 1'b0);
        add_row(32'h7FFF_FFFE, 1'b0, 4'd9, 1'b0, '0, 1'b0, 1'b0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_word(row.word, row.first, row.btype, row.has_exp, row.exp, pick_gap(1'b0));
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // random blocks; the first twelve walk every type to its end
        sent = 0;
        blk = 0;
        while (sent < RAND_ITEMS)
        begin
            if (blk == 3)
                hold_req = 1'b1;
            if (blk == 7)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                wait_drained();
            end
            if (blk < bles_pkg::NumTypes)
                typ = bles_pkg::type_t'(blk);
            else if ($urandom_range(0, 11) == 0)
                typ = bles_pkg::type_t'($urandom_range(bles_pkg::NumTypes, 15));
            else
                typ = bles_pkg::type_t'($urandom_range(0, bles_pkg::NumTypes - 1));
            len = 0;
            if (typ < bles_pkg::NumTypes)
                for (int k = 0; k < 6; k++)
                    len += LEN_TBL[typ][k];
            else
                len = $urandom_range(1, 10);
            mode = $urandom_range(0, 9);
            if (blk >= bles_pkg::NumTypes && mode >= 6 && mode <= 7)
                len = $urandom_range(1, len);
            else if (blk >= bles_pkg::NumTypes && mode >= 8)
                len += $urandom_range(1, 8);
            if (len > RAND_ITEMS - sent)
                len = RAND_ITEMS - sent;
            burst = ($urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < len; i++)
            begin
                send_word(bles_pkg::word_t'($urandom), i == 0,
                          i == 0 ? typ : bles_pkg::type_t'($urandom_range(0, 15)),
                          1'b0, '0, pick_gap(burst));
                sent++;
            end
            blk++;
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
src/bles_pkg.sv
src/bles_in_reg.sv
src/bles_walker.sv
src/bles_out_reg.sv
src/block_layout_endian_swapper_top.sv
sim/tb.sv
